// ===== sv/xcfr_pkg.sv =====
// Shared types and constants of the XOR-checked frame receiver.
`default_nettype none
package xcfr_pkg;

    // Parser and readout states
    typedef enum logic [2:0] {
        S_HUNT  = 3'd0,
        S_LENH  = 3'd1,
        S_LENL  = 3'd2,
        S_CMD   = 3'd3,
        S_PAY   = 3'd4,
        S_CHK   = 3'd5,
        S_DRAIN = 3'd6
    } t_state;

    // Result status codes
    localparam logic [1:0] ST_DATA    = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_BAD_CHK = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // Config register indexes
    localparam logic CFG_START = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    localparam logic [7:0] START_RST = 8'hAA;
    localparam logic [6:0] LIMIT_RST = 7'd64;
    localparam logic [6:0] LEN_SAT   = 7'd64;

    // Controller to datapath
    typedef struct packed {
        logic clr_chk;
        logic ld_lenh;
        logic ld_lenl;
        logic ld_cmd;
        logic wr_pay;
        logic emit_too_long;
        logic emit_bad_chk;
        logic emit_empty;
        logic rd_issue;
        logic rd_first;
    } t_ctl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_marker;
        logic too_long;
        logic len_zero;
        logic len_one;
        logic fill_done;
        logic chk_ok;
        logic rd_last;
        logic slot_ok;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== sv/xcfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module xcfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic                                      i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== sv/xcfr_ctrl.sv =====
// Frame parser state machine: sequences header, payload, check and readout.
`default_nettype none
module xcfr_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_rx_valid,
    output      logic                o_rx_ready,
    input  wire xcfr_pkg::t_dp_stat  i_stat,
    output      xcfr_pkg::t_ctl_cmd  o_cmd
);
    xcfr_pkg::t_state r_state, n_state;
    logic acc;

    // no beat taken during readout; otherwise only when the result slot is free
    assign o_rx_ready = (r_state != xcfr_pkg::S_DRAIN) && i_stat.slot_ok;
    assign acc        = i_rx_valid && o_rx_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= xcfr_pkg::S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            xcfr_pkg::S_HUNT: begin
                if (acc && i_stat.is_marker) n_state = xcfr_pkg::S_LENH;
            end
            xcfr_pkg::S_LENH: begin
                if (acc) n_state = xcfr_pkg::S_LENL;
            end
            xcfr_pkg::S_LENL: begin
                if (acc) n_state = i_stat.too_long ? xcfr_pkg::S_HUNT : xcfr_pkg::S_CMD;
            end
            xcfr_pkg::S_CMD: begin
                if (acc) n_state = i_stat.len_zero ? xcfr_pkg::S_CHK : xcfr_pkg::S_PAY;
            end
            xcfr_pkg::S_PAY: begin
                if (acc && i_stat.fill_done) n_state = xcfr_pkg::S_CHK;
            end
            xcfr_pkg::S_CHK: begin
                if (acc) begin
                    if (i_stat.chk_ok && !i_stat.len_zero && !i_stat.len_one) begin
                        n_state = xcfr_pkg::S_DRAIN;
                    end else begin
                        n_state = xcfr_pkg::S_HUNT;
                    end
                end
            end
            xcfr_pkg::S_DRAIN: begin
                if (i_stat.slot_ok && i_stat.rd_last) n_state = xcfr_pkg::S_HUNT;
            end
            default: n_state = xcfr_pkg::S_HUNT;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            xcfr_pkg::S_HUNT: o_cmd.clr_chk = acc && i_stat.is_marker;
            xcfr_pkg::S_LENH: o_cmd.ld_lenh = acc;
            xcfr_pkg::S_LENL: begin
                o_cmd.ld_lenl       = acc;
                o_cmd.emit_too_long = acc && i_stat.too_long;
            end
            xcfr_pkg::S_CMD: o_cmd.ld_cmd = acc;
            xcfr_pkg::S_PAY: o_cmd.wr_pay = acc;
            xcfr_pkg::S_CHK: begin
                o_cmd.emit_bad_chk = acc && !i_stat.chk_ok;
                o_cmd.emit_empty   = acc && i_stat.chk_ok && i_stat.len_zero;
                o_cmd.rd_issue     = acc && i_stat.chk_ok && !i_stat.len_zero;
                o_cmd.rd_first     = acc && i_stat.chk_ok && !i_stat.len_zero;
            end
            xcfr_pkg::S_DRAIN: o_cmd.rd_issue = i_stat.slot_ok;
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/xcfr_dpath.sv =====
// Frame receiver datapath: header registers, check, payload RAM, result register.
`default_nettype none
module xcfr_dpath #(
    parameter int MAX_PAYLOAD = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wen,
    input  wire logic                i_cfg_idx,
    input  wire logic [7:0]          i_cfg_wdata,
    input  wire logic [7:0]          i_rx_byte,
    input  wire xcfr_pkg::t_ctl_cmd  i_cmd,
    output      xcfr_pkg::t_dp_stat  o_stat,
    output      logic                o_res_valid,
    input  wire logic                i_res_ready,
    output      logic [1:0]          o_status,
    output      logic [7:0]          o_command,
    output      logic [7:0]          o_data_byte,
    output      logic [5:0]          o_byte_index,
    output      logic [6:0]          o_frame_length,
    output      logic                o_last
);
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [6:0] MAX_LEN = 7'(MAX_PAYLOAD);

    logic [7:0] r_start;
    logic [6:0] r_limit;
    logic [7:0] r_len_hi;
    logic [6:0] r_len;
    logic [6:0] r_cnt;
    logic [7:0] r_cmd;
    logic [7:0] r_chk;
    logic [6:0] r_rd_idx;

    logic       r_out_valid;
    logic [1:0] r_out_status;
    logic [7:0] r_out_cmd;
    logic [5:0] r_out_index;
    logic [6:0] r_out_len;
    logic       r_out_last;
    logic       r_out_ram;

    logic [6:0]  eff_limit;
    logic [15:0] full_len;
    logic [6:0]  sat_len;
    logic [6:0]  rd_addr;
    logic        rd_is_last;
    logic [7:0]  ram_q;

    assign eff_limit = (r_limit > MAX_LEN) ? MAX_LEN : r_limit;
    assign full_len  = {r_len_hi, i_rx_byte};
    assign sat_len   = (full_len > 16'(xcfr_pkg::LEN_SAT)) ? xcfr_pkg::LEN_SAT : full_len[6:0];
    assign rd_addr   = i_cmd.rd_first ? 7'd0 : r_rd_idx;
    assign rd_is_last = (8'(rd_addr) + 8'd1) == 8'(r_len);

    always_comb begin
        o_stat.is_marker = (i_rx_byte == r_start);
        o_stat.too_long  = full_len > 16'(eff_limit);
        o_stat.len_zero  = (r_len == 7'd0);
        o_stat.len_one   = (r_len == 7'd1);
        o_stat.fill_done = (8'(r_cnt) + 8'd1) >= 8'(r_len);
        o_stat.chk_ok    = (i_rx_byte == r_chk);
        o_stat.rd_last   = (8'(r_rd_idx) + 8'd1) == 8'(r_len);
        o_stat.slot_ok   = !r_out_valid || i_res_ready;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= xcfr_pkg::START_RST;
            r_limit <= xcfr_pkg::LIMIT_RST;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                xcfr_pkg::CFG_START: r_start <= i_cfg_wdata;
                xcfr_pkg::CFG_LIMIT: r_limit <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // frame header, running check and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_hi <= '0;
            r_len    <= '0;
            r_cnt    <= '0;
            r_cmd    <= '0;
            r_chk    <= '0;
            r_rd_idx <= '0;
        end else begin
            if (i_cmd.clr_chk) r_chk <= '0;
            if (i_cmd.ld_lenh || i_cmd.ld_lenl || i_cmd.ld_cmd || i_cmd.wr_pay) begin
                r_chk <= r_chk ^ i_rx_byte;
            end
            if (i_cmd.ld_lenh) r_len_hi <= i_rx_byte;
            if (i_cmd.ld_lenl) r_len <= full_len[6:0];
            if (i_cmd.ld_cmd) begin
                r_cmd <= i_rx_byte;
                r_cnt <= '0;
            end
            if (i_cmd.wr_pay) r_cnt <= r_cnt + 7'd1;
            if (i_cmd.rd_issue) r_rd_idx <= rd_addr + 7'd1;
        end
    end

    xcfr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_pay),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (rd_addr[AW-1:0]),
        .o_rdata (ram_q)
    );

    // result register; payload bytes come straight from the RAM read register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_too_long || i_cmd.emit_bad_chk || i_cmd.emit_empty
                     || i_cmd.rd_issue) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_too_long) begin
            r_out_status <= xcfr_pkg::ST_TOO_LONG;
            r_out_cmd    <= '0;
            r_out_index  <= '0;
            r_out_len    <= sat_len;
            r_out_last   <= 1'b1;
            r_out_ram    <= 1'b0;
        end else if (i_cmd.emit_bad_chk || i_cmd.emit_empty) begin
            r_out_status <= i_cmd.emit_empty ? xcfr_pkg::ST_EMPTY : xcfr_pkg::ST_BAD_CHK;
            r_out_cmd    <= r_cmd;
            r_out_index  <= '0;
            r_out_len    <= r_len;
            r_out_last   <= 1'b1;
            r_out_ram    <= 1'b0;
        end else if (i_cmd.rd_issue) begin
            r_out_status <= xcfr_pkg::ST_DATA;
            r_out_cmd    <= r_cmd;
            r_out_index  <= rd_addr[5:0];
            r_out_len    <= r_len;
            r_out_last   <= rd_is_last;
            r_out_ram    <= 1'b1;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_command      = r_out_cmd;
    assign o_data_byte    = r_out_ram ? ram_q : 8'd0;
    assign o_byte_index   = r_out_index;
    assign o_frame_length = r_out_len;
    assign o_last         = r_out_last;

`ifndef SYNTH
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_res_ready |=> r_out_valid && $stable(r_out_index)
            && $stable(r_out_status))
        else $error("pending result changed before being taken");
    a_issue_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> (!r_out_valid || i_res_ready))
        else $error("RAM read issued while result slot busy");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_pay |-> (r_cnt < MAX_LEN) && (r_cnt < r_len))
        else $error("payload write beyond frame length");
    a_drain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> (rd_addr < r_len))
        else $error("payload read beyond frame length");
`endif

endmodule
`default_nettype wire

// ===== sv/xor_checked_frame_receiver.sv =====
// Top level of the XOR-checked frame receiver.
`default_nettype none
// Parses a byte stream into frames: start marker, 16-bit big-endian length,
// command byte, payload, XOR check byte (over both length bytes, the command
// and the payload). While parsing, one byte beat is taken per cycle as long as
// the result slot is free; a result that waits to be taken holds the input.
// A frame whose check matches is read back out of the payload RAM one entry per
// cycle while the sink takes results, through its single registered read port;
// the first entry is read as the check byte is taken and any others in a
// readout state that follows; during that readout no input beat is taken. An
// empty good frame, a check mismatch and an over-limit length each give a
// single result and need no readout; after an error the parser goes back to
// hunting for the start marker. Config writes (index 0 start marker, index 1
// length limit) are meant for idle periods; a length limit above MAX_PAYLOAD
// acts as MAX_PAYLOAD.
module xor_checked_frame_receiver #(
    parameter int MAX_PAYLOAD = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write port
    input  wire logic        i_cfg_wen,
    input  wire logic        i_cfg_idx,
    input  wire logic [7:0]  i_cfg_wdata,
    // received bytes
    input  wire logic        i_rx_valid,
    output      logic        o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    // results
    output      logic        o_res_valid,
    input  wire logic        i_res_ready,
    output      logic [1:0]  o_status,
    output      logic [7:0]  o_command,
    output      logic [7:0]  o_data_byte,
    output      logic [5:0]  o_byte_index,
    output      logic [6:0]  o_frame_length,
    output      logic        o_last
);
    xcfr_pkg::t_ctl_cmd cmd;
    xcfr_pkg::t_dp_stat stat;

    // sequencing: header fields, payload fill, check, readout
    xcfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // registers, compares, payload RAM and the result register
    xcfr_dpath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_rx_byte      (i_rx_byte),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_status       (o_status),
        .o_command      (o_command),
        .o_data_byte    (o_data_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_length (o_frame_length),
        .o_last         (o_last)
    );

endmodule
`default_nettype wire

// ===== tb/sv/xor_checked_frame_receiver_checker.sv =====
`timescale 1ns / 1ps
// Frame receiver scoreboard: predicts results from the accepted byte beats and compares them.
module xor_checked_frame_receiver_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wen,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_rx_valid,
    input  logic       i_rx_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  logic [1:0] i_status,
    input  logic [7:0] i_command,
    input  logic [7:0] i_data_byte,
    input  logic [5:0] i_byte_index,
    input  logic [6:0] i_frame_length,
    input  logic       i_last,
    input  logic       i_wrap_up,
    output int         o_pending,
    output int         o_fail_count
);
    localparam int PAYLOAD_DEPTH = 64;
    localparam int PRINT_CAP     = 100;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] command;
        logic [7:0] data_byte;
        logic [5:0] byte_index;
        logic [6:0] frame_length;
        logic       last;
    } t_frame_result;

    t_frame_result expected_results[$];
    t_frame_result got_result;
    t_frame_result want_result;

    // shadow of the parser
    xcfr_pkg::t_state parse_state;
    logic [15:0] frame_len;
    logic [6:0]  fill_count;
    logic [7:0]  held_cmd;
    logic [7:0]  xor_acc;
    logic [7:0]  payload_mem [PAYLOAD_DEPTH];
    logic [7:0]  marker_reg;
    logic [6:0]  limit_reg;

    int fail_count   = 0;
    int result_count = 0;
    bit wrapped_up   = 1'b0;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_CAP)
            $display("[%0t] %s", $time, msg);
        fail_count++;
    endtask

    function automatic void push_result(input logic [1:0] st, input logic [7:0] cmd,
                                        input logic [7:0] data, input logic [5:0] idx,
                                        input logic [6:0] len, input logic lst);
        t_frame_result r;
        r.status       = st;
        r.command      = cmd;
        r.data_byte    = data;
        r.byte_index   = idx;
        r.frame_length = len;
        r.last         = lst;
        expected_results.push_back(r);
    endfunction

    // one received byte through the parser; queues whatever results it causes
    task automatic predict_from_byte(input logic [7:0] b);
        logic [6:0] eff_limit;
        logic [6:0] out_len;
        int         i;
        eff_limit = (limit_reg > xcfr_pkg::LEN_SAT) ? xcfr_pkg::LEN_SAT : limit_reg;
        case (parse_state)
            xcfr_pkg::S_LENH: begin
                frame_len   = {b, 8'h00};
                xor_acc     = xor_acc ^ b;
                parse_state = xcfr_pkg::S_LENL;
            end
            xcfr_pkg::S_LENL: begin
                frame_len[7:0] = b;
                xor_acc        = xor_acc ^ b;
                // limit is sampled here only
                if (frame_len > {9'd0, eff_limit}) begin
                    out_len = (frame_len > {9'd0, xcfr_pkg::LEN_SAT})
                              ? xcfr_pkg::LEN_SAT : frame_len[6:0];
                    push_result(xcfr_pkg::ST_TOO_LONG, 8'h00, 8'h00, 6'd0, out_len, 1'b1);
                    parse_state = xcfr_pkg::S_HUNT;
                end else begin
                    parse_state = xcfr_pkg::S_CMD;
                end
            end
            xcfr_pkg::S_CMD: begin
                held_cmd    = b;
                xor_acc     = xor_acc ^ b;
                fill_count  = 7'd0;
                parse_state = (frame_len != 16'd0) ? xcfr_pkg::S_PAY : xcfr_pkg::S_CHK;
            end
            xcfr_pkg::S_PAY: begin
                if (fill_count < 7'(PAYLOAD_DEPTH))
                    payload_mem[fill_count[5:0]] = b;
                fill_count = fill_count + 7'd1;
                xor_acc    = xor_acc ^ b;
                if ({9'd0, fill_count} >= frame_len)
                    parse_state = xcfr_pkg::S_CHK;
            end
            xcfr_pkg::S_CHK: begin
                if (b == xor_acc) begin
                    if (frame_len == 16'd0) begin
                        push_result(xcfr_pkg::ST_EMPTY, held_cmd, 8'h00, 6'd0, 7'd0, 1'b1);
                    end else begin
                        out_len = (frame_len > {9'd0, xcfr_pkg::LEN_SAT})
                                  ? xcfr_pkg::LEN_SAT : frame_len[6:0];
                        for (i = 0; i < int'(out_len); i++)
                            push_result(xcfr_pkg::ST_DATA, held_cmd, payload_mem[i],
                                        i[5:0], out_len, (i + 1 == int'(out_len)));
                    end
                end else begin
                    push_result(xcfr_pkg::ST_BAD_CHK, held_cmd, 8'h00, 6'd0,
                                frame_len[6:0], 1'b1);
                end
                parse_state = xcfr_pkg::S_HUNT;
            end
            default: begin
                // hunting: anything but the marker is dropped
                if (b == marker_reg) begin
                    parse_state = xcfr_pkg::S_LENH;
                    xor_acc     = 8'h00;
                end else begin
                    parse_state = xcfr_pkg::S_HUNT;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_state = xcfr_pkg::S_HUNT;
            frame_len   = 16'd0;
            fill_count  = 7'd0;
            held_cmd    = 8'h00;
            xor_acc     = 8'h00;
            marker_reg  = xcfr_pkg::START_RST;
            limit_reg   = xcfr_pkg::LIMIT_RST;
            expected_results.delete();
        end else begin
            if (i_rx_valid && i_rx_ready)
                predict_from_byte(i_rx_byte);
            if (i_cfg_wen) begin
                if (i_cfg_idx == xcfr_pkg::CFG_START)
                    marker_reg = i_cfg_wdata;
                else
                    limit_reg = i_cfg_wdata[6:0];
            end
            if (i_res_valid && i_res_ready) begin
                got_result.status       = i_status;
                got_result.command      = i_command;
                got_result.data_byte    = i_data_byte;
                got_result.byte_index   = i_byte_index;
                got_result.frame_length = i_frame_length;
                got_result.last         = i_last;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf(
                        "result %0d unexpected: st=%0d cmd=%02h data=%02h idx=%0d len=%0d last=%0d",
                        result_count, i_status, i_command, i_data_byte, i_byte_index,
                        i_frame_length, i_last));
                end else begin
                    want_result = expected_results.pop_front();
                    if (got_result != want_result)
                        report_mismatch($sformatf(
                            {"result %0d: got st=%0d cmd=%02h data=%02h idx=%0d len=%0d last=%0d",
                             " / want st=%0d cmd=%02h data=%02h idx=%0d len=%0d last=%0d"},
                            result_count, i_status, i_command, i_data_byte, i_byte_index,
                            i_frame_length, i_last, want_result.status, want_result.command,
                            want_result.data_byte, want_result.byte_index,
                            want_result.frame_length, want_result.last));
                end
                result_count++;
            end
            if (i_wrap_up && !wrapped_up) begin
                wrapped_up = 1'b1;
                if (expected_results.size() != 0)
                    report_mismatch($sformatf("%0d expected results never arrived",
                                              expected_results.size()));
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== tb/sv/xor_checked_frame_receiver_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the XOR-checked frame receiver: clock, reset, byte stimulus and verdict.
module xor_checked_frame_receiver_tb;
    localparam int HOLD_OFF_CYCLES = 160;     // long sink stall, fills the block
    localparam int SETTLE_CYCLES   = 8;       // quiet time before a config write
    localparam int ITEMS_PER_PHASE = 36;      // byte beats per config setting
    localparam int CYCLE_LIMIT     = 200000;  // far above the slowest legal run

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_wen   = 1'b0;
    logic       cfg_idx   = xcfr_pkg::CFG_START;
    logic [7:0] cfg_wdata = 8'h00;
    logic       rx_valid  = 1'b0;
    logic       rx_ready;
    logic [7:0] rx_byte   = 8'h00;
    logic       res_valid;
    logic       res_ready = 1'b0;
    logic [1:0] status;
    logic [7:0] command;
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic [6:0] frame_length;
    logic       res_last;
    logic       wrap_up   = 1'b0;
    int         pending;
    int         fail_count;

    // what the stimulus believes is configured, used to build well-formed frames
    logic [7:0] cur_marker = xcfr_pkg::START_RST;
    logic [6:0] cur_limit  = xcfr_pkg::LIMIT_RST;
    logic [7:0] frame_buf [64];

    int burst_left   = 0;
    int sent_count   = 0;
    int cycle_count  = 0;
    bit hold_off_req = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    xor_checked_frame_receiver u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wen      (cfg_wen),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata),
        .i_rx_valid     (rx_valid),
        .o_rx_ready     (rx_ready),
        .i_rx_byte      (rx_byte),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_status       (status),
        .o_command      (command),
        .o_data_byte    (data_byte),
        .o_byte_index   (byte_index),
        .o_frame_length (frame_length),
        .o_last         (res_last)
    );

    xor_checked_frame_receiver_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wen      (cfg_wen),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata),
        .i_rx_valid     (rx_valid),
        .i_rx_ready     (rx_ready),
        .i_rx_byte      (rx_byte),
        .i_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .i_status       (status),
        .i_command      (command),
        .i_data_byte    (data_byte),
        .i_byte_index   (byte_index),
        .i_frame_length (frame_length),
        .i_last         (res_last),
        .i_wrap_up      (wrap_up),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    // One byte beat. The sender runs in bursts; between bursts valid drops for a
    // random gap (sometimes none). Inside a burst valid stays high and only the
    // payload moves on, so back-to-back beats never toggle valid.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                rx_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        rx_valid <= 1'b1;
        rx_byte  <= b;
        sent_count++;
        @(posedge clk);
        while (!rx_ready) @(posedge clk);
    endtask

    // marker and big-endian length
    task automatic send_head(input logic [15:0] len);
        send_byte(cur_marker);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
    endtask

    // command, payload from frame_buf, check byte (optionally spoiled)
    task automatic send_body(input logic [7:0] cmd, input logic [15:0] len, input bit bad_chk);
        logic [7:0] chk;
        int         i;
        chk = len[15:8] ^ len[7:0] ^ cmd;
        for (i = 0; i < int'(len); i++)
            chk = chk ^ frame_buf[i];
        if (bad_chk)
            chk = chk ^ 8'($urandom_range(1, 255));
        send_byte(cmd);
        for (i = 0; i < int'(len); i++)
            send_byte(frame_buf[i]);
        send_byte(chk);
    endtask

    // Mostly short frames; a few sit on the limit, one over it, at the full
    // payload size, or carry a wild 16-bit length.
    task automatic send_random_frame();
        logic [15:0] len;
        int          eff;
        int          pick;
        int          i;
        eff  = (cur_limit > xcfr_pkg::LEN_SAT) ? int'(xcfr_pkg::LEN_SAT) : int'(cur_limit);
        pick = $urandom_range(0, 99);
        if (pick < 60)
            len = 16'($urandom_range(0, (eff < 8) ? eff : 8));
        else if (pick < 68)
            len = 16'(eff + 1);
        else if (pick < 76)
            len = 16'($urandom_range(0, 65535));
        else if (pick < 80)
            len = 16'(eff);
        else if (pick < 83)
            len = 16'd64;
        else
            len = 16'($urandom_range(0, (eff < 16) ? eff : 16));
        for (i = 0; i < 64; i++)
            frame_buf[i] = 8'($urandom_range(0, 255));
        send_head(len);
        // over-limit frames end at the length; the parser is hunting again
        if (int'(len) <= eff)
            send_body(8'($urandom_range(0, 255)), len, $urandom_range(0, 99) < 15);
    endtask

    // Stop sending, let every expected result come out, then a few quiet cycles
    // so a readout with nothing left to predict has finished too.
    task automatic drain_results();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // both registers, back to back; bit 7 of the limit write is don't-care
    task automatic write_cfg(input logic [7:0] marker, input logic [6:0] limit);
        logic junk;
        junk = ($urandom_range(0, 1) == 1);
        cfg_wen   <= 1'b1;
        cfg_idx   <= xcfr_pkg::CFG_START;
        cfg_wdata <= marker;
        @(posedge clk);
        cfg_idx   <= xcfr_pkg::CFG_LIMIT;
        cfg_wdata <= {junk, limit};
        @(posedge clk);
        cfg_wen    <= 1'b0;
        cur_marker = marker;
        cur_limit  = limit;
    endtask

    // Result sink: segments with their own ready odds (from always ready down to
    // mostly stalled). A hold-off request parks ready low for a long stretch.
    initial begin : sink_side
        int odds;
        int seg_len;
        forever begin
            if (hold_off_req) begin
                res_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            case ($urandom_range(0, 3))
                0:       odds = 8;
                1:       odds = 6;
                2:       odds = 4;
                default: odds = 1;
            endcase
            seg_len = $urandom_range(4, 40);
            repeat (seg_len) begin
                res_ready <= ($urandom_range(0, 7) < odds);
                @(posedge clk);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("xor_checked_frame_receiver_tb: done, errors");
            $finish;
        end
    end

    initial begin : stimulus
        int         ph;
        int         phase_items;
        int         sent_mark;
        int         pick;
        logic [7:0] marker;
        logic [6:0] limit;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, reset config (marker 0xAA, limit 64) ---
        // stray bytes while hunting: no result
        send_byte(8'h00);
        send_byte(8'hFF);
        // empty frame, good check, lowest command
        send_head(16'd0);
        send_body(8'h00, 16'd0, 1'b0);
        // largest length: rejected, reported length saturates
        send_head(16'hFFFF);
        // two-byte frame with extreme payload values, top command
        frame_buf[0] = 8'hFF;
        frame_buf[1] = 8'h00;
        send_head(16'd2);
        send_body(8'hFF, 16'd2, 1'b0);
        // spoiled check
        frame_buf[0] = 8'h5A;
        send_head(16'd1);
        send_body(8'h3C, 16'd1, 1'b1);
        // config changed after the length passed: frame still good, new
        // marker only counts from the next hunt
        frame_buf[0] = 8'h81;
        frame_buf[1] = 8'h7E;
        send_head(16'd2);
        drain_results();
        write_cfg(8'h00, 7'd1);
        send_body(8'h81, 16'd2, 1'b0);

        // --- random phases, one config setting each ---
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    marker = 8'($urandom_range(1, 254));
                    limit  = 7'd64;
                end
                1: begin
                    marker = 8'h00;
                    limit  = 7'd0;
                end
                2: begin
                    marker = 8'hFF;
                    limit  = 7'h7F;   // above the payload size, acts as 64
                end
                3: begin
                    marker = 8'($urandom_range(0, 255));
                    limit  = 7'($urandom_range(1, 12));
                end
                4: begin
                    marker = 8'($urandom_range(0, 255));
                    limit  = 7'd65;
                end
                default: begin
                    marker = xcfr_pkg::START_RST;
                    limit  = xcfr_pkg::LIMIT_RST;
                end
            endcase
            drain_results();
            write_cfg(marker, limit);
            // back-pressure: sink holds off while frames keep coming
            if (ph == 2 || ph == 4)
                hold_off_req = 1'b1;
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                sent_mark = sent_count;
                pick      = $urandom_range(0, 99);
                if (pick < 72) begin
                    send_random_frame();
                end else if (pick < 82) begin
                    // frame cut short; following bytes get parsed as its tail
                    send_byte(cur_marker);
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
                end else begin
                    // line noise, mostly dropped by the hunt
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
                end
                phase_items += sent_count - sent_mark;
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        wrap_up <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0)
            $display("xor_checked_frame_receiver_tb: done, clean");
        else
            $display("xor_checked_frame_receiver_tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/xcfr_pkg.sv
sv/xcfr_ram.sv
sv/xcfr_ctrl.sv
sv/xcfr_dpath.sv
sv/xor_checked_frame_receiver.sv
tb/sv/xor_checked_frame_receiver_checker.sv
tb/sv/xor_checked_frame_receiver_tb.sv
